// ===== rtl/lrb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the link reconnect backoff block.
// No dependencies; used by lrb_next_state and link_reconnect_backoff_fsm_unit.
package lrb_pkg;

	localparam int DELAY_W       = 16;
	localparam int ATTEMPT_W     = 8;
	localparam int ACTION_W      = 3;
	localparam int LINK_W        = 2;
	localparam int CFG_IDX_W     = 3;
	localparam int USED_W        = 3;
	localparam int DELAY_REGS    = 4;
	localparam int DELAY_ENTRIES = 4;
	localparam int USED_MAX      = (DELAY_ENTRIES < DELAY_REGS) ? DELAY_ENTRIES : DELAY_REGS;
	localparam int IDX_W         = $clog2(DELAY_REGS);

	// Event codes
	localparam logic [ACTION_W-1:0] ACT_SET_WANTED   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_CONNECTED    = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_DISCONNECTED = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_FAILED       = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_UNAVAILABLE  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_TICK         = 3'd5;

	// Link state codes
	localparam logic [LINK_W-1:0] LINK_OFF        = 2'd0;
	localparam logic [LINK_W-1:0] LINK_CONNECTING = 2'd1;
	localparam logic [LINK_W-1:0] LINK_CONNECTED  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_THIRD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FOURTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAYS_USED  = 3'd4;

	// Reset values of the configuration registers
	localparam logic [DELAY_W-1:0] RST_DELAY_FIRST  = 16'd5;
	localparam logic [DELAY_W-1:0] RST_DELAY_SECOND = 16'd10;
	localparam logic [DELAY_W-1:0] RST_DELAY_THIRD  = 16'd20;
	localparam logic [DELAY_W-1:0] RST_DELAY_FOURTH = 16'd30;
	localparam logic [USED_W-1:0]  RST_DELAYS_USED  = 3'd4;

	localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = '1;

	typedef logic [DELAY_REGS-1:0][DELAY_W-1:0] delay_tbl_t;

	typedef struct packed {
		logic [LINK_W-1:0]    link_state;
		logic                 wanted;
		logic [ATTEMPT_W-1:0] attempt;
		logic [DELAY_W-1:0]   next_delay;
		logic                 error_rec;
		logic [DELAY_W-1:0]   countdown;
		logic                 running;
	} lrb_state_t;

	typedef struct packed {
		logic changed;
		logic open_req;
		logic close_req;
		logic report;
	} lrb_flags_t;

endpackage

// ===== rtl/lrb_next_state.sv =====
`timescale 1ns / 1ps
// Next-state and event-flag logic of the reconnect controller, one event per call.
// Depends on lrb_pkg.
module lrb_next_state (
	input  lrb_pkg::lrb_state_t             cur,
	input  logic [lrb_pkg::ACTION_W-1:0]    action,
	input  logic                            want_value,
	input  logic                            reason_present,
	input  lrb_pkg::delay_tbl_t             delays,
	input  logic [lrb_pkg::USED_W-1:0]      delays_used,
	output lrb_pkg::lrb_state_t             nxt,
	output lrb_pkg::lrb_flags_t             flags
);
	import lrb_pkg::*;

	logic [USED_W-1:0]    used_eff;
	logic [USED_W-1:0]    last_idx;
	logic [IDX_W-1:0]     tbl_idx;
	logic [DELAY_W-1:0]   retry_delay;
	logic [ATTEMPT_W-1:0] attempt_inc;

	// Pick the retry delay: attempt count clamped to the last entry in use.
	always_comb begin
		used_eff = (delays_used > USED_W'(USED_MAX)) ? USED_W'(USED_MAX) : delays_used;
		if (used_eff == '0)
			used_eff = USED_W'(1);
		last_idx = used_eff - USED_W'(1);
		if (cur.attempt > ATTEMPT_W'(last_idx))
			tbl_idx = last_idx[IDX_W-1:0];
		else
			tbl_idx = cur.attempt[IDX_W-1:0];
		retry_delay = delays[tbl_idx];
		attempt_inc = (cur.attempt == ATTEMPT_MAX) ? cur.attempt : cur.attempt + ATTEMPT_W'(1);
	end

	always_comb begin
		nxt   = cur;
		flags = '0;
		unique case (action)
			ACT_SET_WANTED: begin
				nxt.wanted     = want_value;
				nxt.countdown  = '0;
				nxt.running    = 1'b0;
				nxt.attempt    = '0;
				nxt.next_delay = '0;
				nxt.error_rec  = 1'b0;
				nxt.link_state = want_value ? LINK_CONNECTING : LINK_OFF;
				flags.changed   = 1'b1;
				flags.open_req  = want_value;
				flags.close_req = !want_value;
			end
			ACT_CONNECTED: begin
				nxt.countdown  = '0;
				nxt.running    = 1'b0;
				nxt.attempt    = '0;
				nxt.next_delay = '0;
				nxt.error_rec  = 1'b0;
				nxt.link_state = LINK_CONNECTED;
				flags.changed  = 1'b1;
				flags.report   = (cur.attempt != '0) || cur.error_rec;
			end
			ACT_DISCONNECTED: begin
				if (!cur.wanted) begin
					nxt.link_state = LINK_OFF;
					flags.changed  = 1'b1;
				end else if (cur.link_state == LINK_CONNECTED) begin
					nxt.error_rec  = 1'b1;
					nxt.next_delay = retry_delay;
					nxt.attempt    = attempt_inc;
					nxt.countdown  = retry_delay;
					nxt.running    = 1'b1;
					nxt.link_state = LINK_CONNECTING;
					flags.changed  = 1'b1;
					flags.report   = 1'b1;
				end
			end
			ACT_FAILED: begin
				if (cur.wanted) begin
					nxt.error_rec  = reason_present;
					nxt.next_delay = retry_delay;
					nxt.attempt    = attempt_inc;
					nxt.countdown  = retry_delay;
					nxt.running    = 1'b1;
					nxt.link_state = LINK_CONNECTING;
					flags.changed  = 1'b1;
					flags.report   = 1'b1;
				end
			end
			ACT_UNAVAILABLE: begin
				if (cur.wanted && cur.link_state == LINK_CONNECTED) begin
					nxt.error_rec  = reason_present;
					nxt.next_delay = '0;
					nxt.link_state = LINK_CONNECTING;
					flags.changed  = 1'b1;
					flags.report   = 1'b1;
				end
			end
			ACT_TICK: begin
				if (cur.running) begin
					if (cur.countdown <= DELAY_W'(1)) begin
						nxt.countdown  = '0;
						nxt.running    = 1'b0;
						flags.open_req = cur.wanted && (cur.link_state != LINK_CONNECTED);
					end else begin
						nxt.countdown = cur.countdown - DELAY_W'(1);
					end
				end
			end
			default: begin
				// unused codes: hold everything
			end
		endcase
	end

endmodule

// ===== rtl/link_reconnect_backoff_fsm_unit.sv =====
`timescale 1ns / 1ps
// Top level of the link reconnect controller with a retry delay table.
// Depends on lrb_pkg and lrb_next_state.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event word: action,
//   want_value, reason_present. Output channel (out_valid/out_ready)
//   returns exactly one result word per event: link state, the four event
//   flags, next delay, attempt count and error flag after that event.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the four
//   delays (indexes 0..3) and the entry count (index 4); cfg_ready is always
//   high. A zero entry count write is dropped; other indexes are ignored.
//   Pipeline: an accepted event passes the input register, then the result
//   register. Throughput: one event per cycle while out_ready stays high;
//   the whole update is one pass through the next-state logic between the
//   two registers, with the controller state written as the result is
//   loaded.
//   Reset: state goes to off/not wanted/all counters zero, delays to
//   5/10/20/30 seconds with four entries in use, both stages empty.
//   Stall: while out_ready is low the result holds, the input register holds
//   its word, and in_ready drops once that register is full too.
module link_reconnect_backoff_fsm_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// event channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lrb_pkg::ACTION_W-1:0]      action,
	input  logic                              want_value,
	input  logic                              reason_present,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lrb_pkg::LINK_W-1:0]        link_state_out,
	output logic                              state_changed,
	output logic                              open_request,
	output logic                              close_request,
	output logic                              report_message,
	output logic [lrb_pkg::DELAY_W-1:0]       next_delay_out,
	output logic [lrb_pkg::ATTEMPT_W-1:0]     attempt_out,
	output logic                              error_flag_out,
	// config channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lrb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lrb_pkg::DELAY_W-1:0]       cfg_data
);
	import lrb_pkg::*;

	// configuration registers
	delay_tbl_t         delays_q;
	logic [USED_W-1:0]  delays_used_q;

	// controller state
	lrb_state_t         st_q;

	// input stage
	logic                vld_s1;
	logic [ACTION_W-1:0] action_s1;
	logic                want_s1;
	logic                reason_s1;

	// result stage
	logic                vld_s2;
	lrb_state_t          res_st_s2;
	lrb_flags_t          res_fl_s2;

	// next-state logic outputs
	lrb_state_t          nxt_st;
	lrb_flags_t          nxt_fl;

	logic                adv;

	assign cfg_ready = 1'b1;

	// Advance the input word when the result register is empty or being taken.
	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;

	// Config writes: delays take the full word, entry count takes three bits,
	// zero entry count is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delays_q[0]   <= RST_DELAY_FIRST;
			delays_q[1]   <= RST_DELAY_SECOND;
			delays_q[2]   <= RST_DELAY_THIRD;
			delays_q[3]   <= RST_DELAY_FOURTH;
			delays_used_q <= RST_DELAYS_USED;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DELAY_FIRST:  delays_q[0] <= cfg_data;
				CFG_DELAY_SECOND: delays_q[1] <= cfg_data;
				CFG_DELAY_THIRD:  delays_q[2] <= cfg_data;
				CFG_DELAY_FOURTH: delays_q[3] <= cfg_data;
				CFG_DELAYS_USED: begin
					if (cfg_data[USED_W-1:0] != '0)
						delays_used_q <= cfg_data[USED_W-1:0];
				end
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	// Input register: valid bit reset, payload free-running on accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_ready)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			want_s1   <= want_value;
			reason_s1 <= reason_present;
		end
	end

	lrb_next_state u_next (
		.cur            (st_q),
		.action         (action_s1),
		.want_value     (want_s1),
		.reason_present (reason_s1),
		.delays         (delays_q),
		.delays_used    (delays_used_q),
		.nxt            (nxt_st),
		.flags          (nxt_fl)
	);

	// Controller state commits as the event's result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{link_state: LINK_OFF, wanted: 1'b0, attempt: '0, next_delay: '0,
			          error_rec: 1'b0, countdown: '0, running: 1'b0};
			vld_s2 <= 1'b0;
		end else begin
			if (adv) begin
				st_q   <= nxt_st;
				vld_s2 <= 1'b1;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_st_s2 <= nxt_st;
			res_fl_s2 <= nxt_fl;
		end
	end

	assign out_valid      = vld_s2;
	assign link_state_out = res_st_s2.link_state;
	assign state_changed  = res_fl_s2.changed;
	assign open_request   = res_fl_s2.open_req;
	assign close_request  = res_fl_s2.close_req;
	assign report_message = res_fl_s2.report;
	assign next_delay_out = res_st_s2.next_delay;
	assign attempt_out    = res_st_s2.attempt;
	assign error_flag_out = res_st_s2.error_rec;

	// A stopped countdown always reads zero.
	a_idle_timer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.running |-> st_q.countdown == '0)
		else $error("countdown nonzero while stopped");

	// The retry timer only runs while the link is wanted.
	a_timer_needs_want: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.running |-> st_q.wanted)
		else $error("retry timer running on an unwanted link");

	// An open request from expiry leaves the timer stopped.
	a_open_stops_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && nxt_fl.open_req && action_s1 == ACT_TICK) |=> !st_q.running)
		else $error("timer still running after retry fired");

	// A held input word keeps its payload until it moves on.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(action_s1) && $stable(want_s1)))
		else $error("input register changed while stalled");

endmodule

// ===== tb/tb_link_reconnect_backoff_fsm_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for link_reconnect_backoff_fsm_unit: random event and
// config traffic, checked word by word against an in-bench link predictor.
// Depends on lrb_pkg and the RTL of the unit.
module tb_link_reconnect_backoff_fsm_unit;

	import lrb_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int PHASES        = 8;
	localparam int PHASE_WORDS   = 220;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;

	// Event codes the block must treat as no-ops
	localparam logic [ACTION_W-1:0]  ACT_SPARE_LO = 3'd6;
	localparam logic [ACTION_W-1:0]  ACT_SPARE_HI = 3'd7;
	// Register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 3'd7;

	// One pending word for the driver: an event or a register write
	typedef struct packed {
		logic                 is_cfg;
		logic [ACTION_W-1:0]  act;
		logic                 want;
		logic                 why;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [DELAY_W-1:0]   reg_val;
	} link_word_t;

	// Everything one result word carries, in port order
	typedef struct packed {
		logic [LINK_W-1:0]    link;
		logic                 changed;
		logic                 open_req;
		logic                 close_req;
		logic                 report;
		logic [DELAY_W-1:0]   delay;
		logic [ATTEMPT_W-1:0] tries;
		logic                 err;
	} link_result_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [ACTION_W-1:0]   action = ACT_TICK;
	logic                  want_value = 1'b0;
	logic                  reason_present = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [LINK_W-1:0]     link_state_out;
	logic                  state_changed;
	logic                  open_request;
	logic                  close_request;
	logic                  report_message;
	logic [DELAY_W-1:0]    next_delay_out;
	logic [ATTEMPT_W-1:0]  attempt_out;
	logic                  error_flag_out;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_DELAY_FIRST;
	logic [DELAY_W-1:0]    cfg_data = '0;

	// Predicted controller state and delay registers, reset values
	logic [LINK_W-1:0]     link_now = LINK_OFF;
	logic                  want_now = 1'b0;
	logic [ATTEMPT_W-1:0]  tries = '0;
	logic [DELAY_W-1:0]    delay_next = '0;
	logic                  err_now = 1'b0;
	logic [DELAY_W-1:0]    count_left = '0;
	logic                  count_on = 1'b0;
	logic [DELAY_W-1:0]    dly_tbl [DELAY_REGS] = '{RST_DELAY_FIRST, RST_DELAY_SECOND,
		RST_DELAY_THIRD, RST_DELAY_FOURTH};
	logic [USED_W-1:0]     entries_used = RST_DELAYS_USED;

	link_word_t            work_q [$];
	link_result_t          results_due [$];
	logic                  ev_took = 1'b0;
	logic                  cfg_took = 1'b0;
	int                    words_planned = 0;
	int                    events_planned = 0;
	int                    words_taken = 0;
	int                    results_seen = 0;
	int                    mismatches = 0;
	int                    gap_left = 0;
	int                    calm_left = 0;
	int                    stall_left = 0;
	int                    sink_calm = 0;
	int                    cycle_count = 0;

	link_reconnect_backoff_fsm_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.want_value     (want_value),
		.reason_present (reason_present),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.link_state_out (link_state_out),
		.state_changed  (state_changed),
		.open_request   (open_request),
		.close_request  (close_request),
		.report_message (report_message),
		.next_delay_out (next_delay_out),
		.attempt_out    (attempt_out),
		.error_flag_out (error_flag_out),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly no pause, sometimes a few cycles, rarely a long one
	function automatic int draw_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// One random bit
	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	// Start a retry: look up the delay for this attempt, clamped to the
	// last entry in use, bump the saturating attempt count, arm the countdown.
	function automatic void arm_retry();
		int span;
		int pick;
		span = entries_used;
		if (span > USED_MAX)
			span = USED_MAX;
		if (span < 1)
			span = 1;
		pick = tries;
		if (pick > span - 1)
			pick = span - 1;
		delay_next = dly_tbl[pick];
		if (tries != ATTEMPT_MAX)
			tries = tries + 1'b1;
		count_left = delay_next;
		count_on = 1'b1;
		link_now = LINK_CONNECTING;
	endfunction

	// Advance the predicted controller by one event and return its result word
	function automatic link_result_t next_link_result(input logic [ACTION_W-1:0] act,
		input logic w, input logic why);
		link_result_t res;
		res = '0;
		case (act)
		ACT_SET_WANTED: begin
			want_now = w;
			count_left = '0;
			count_on = 1'b0;
			tries = '0;
			delay_next = '0;
			err_now = 1'b0;
			link_now = w ? LINK_CONNECTING : LINK_OFF;
			res.changed = 1'b1;
			res.open_req = w;
			res.close_req = !w;
		end
		ACT_CONNECTED: begin
			// a message only when coming back from a retry or an error
			res.report = (tries != 0) || err_now;
			count_left = '0;
			count_on = 1'b0;
			tries = '0;
			delay_next = '0;
			err_now = 1'b0;
			link_now = LINK_CONNECTED;
			res.changed = 1'b1;
		end
		ACT_DISCONNECTED: begin
			if (!want_now) begin
				link_now = LINK_OFF;
				res.changed = 1'b1;
			end else if (link_now == LINK_CONNECTED) begin
				err_now = 1'b1;
				arm_retry();
				res.changed = 1'b1;
				res.report = 1'b1;
			end
		end
		ACT_FAILED: begin
			if (want_now) begin
				err_now = why;
				arm_retry();
				res.changed = 1'b1;
				res.report = 1'b1;
			end
		end
		ACT_UNAVAILABLE: begin
			if (want_now && link_now == LINK_CONNECTED) begin
				err_now = why;
				delay_next = '0;
				link_now = LINK_CONNECTING;
				res.changed = 1'b1;
				res.report = 1'b1;
			end
		end
		ACT_TICK: begin
			// a countdown of zero or one fires on this tick
			if (count_on) begin
				if (count_left <= 1) begin
					count_left = '0;
					count_on = 1'b0;
					res.open_req = want_now && link_now != LINK_CONNECTED;
				end else begin
					count_left = count_left - 1'b1;
				end
			end
		end
		default: ;
		endcase
		res.link = link_now;
		res.delay = delay_next;
		res.tries = tries;
		res.err = err_now;
		return res;
	endfunction

	task automatic queue_event(input logic [ACTION_W-1:0] act, input logic w, input logic why);
		link_word_t item;
		item = '0;
		item.act = act;
		item.want = w;
		item.why = why;
		work_q.push_back(item);
		words_planned++;
		events_planned++;
	endtask

	task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
		link_word_t item;
		item = '0;
		item.is_cfg = 1'b1;
		item.reg_idx = idx;
		item.reg_val = val;
		work_q.push_back(item);
		words_planned++;
	endtask

	// Driver: present one word at a time, hold it until taken, then pause.
	// Register writes wait until every outstanding result has come back.
	always @(negedge clk) begin
		link_word_t w;
		logic ev_next;
		logic cfg_next;
		if (arst_n) begin
			ev_next = in_valid && !ev_took;
			cfg_next = cfg_valid && !cfg_took;
			if (!ev_next && !cfg_next) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (work_q.size() != 0 &&
					(!work_q[0].is_cfg || results_due.size() == 0)) begin
					w = work_q.pop_front();
					if (w.is_cfg) begin
						cfg_index <= w.reg_idx;
						cfg_data <= w.reg_val;
						cfg_next = 1'b1;
					end else begin
						action <= w.act;
						want_value <= w.want;
						reason_present <= w.why;
						ev_next = 1'b1;
						// now and then run a stretch back to back
						if (calm_left != 0)
							calm_left--;
						else if ($urandom_range(0, 149) == 0)
							calm_left = $urandom_range(20, 80);
						gap_left = (calm_left != 0) ? 0 : draw_pause();
					end
				end
			end
			in_valid <= ev_next;
			cfg_valid <= cfg_next;
		end
	end

	// Result side back-pressure: random stalls with occasional open stretches
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (sink_calm != 0) begin
			sink_calm--;
			out_ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 199) == 0)
				sink_calm = $urandom_range(20, 100);
			else
				stall_left = draw_pause();
		end
	end

	// Monitor: track writes and events on acceptance, check each result word
	// against the oldest prediction.
	always @(posedge clk) begin
		link_result_t got_res;
		link_result_t want_res;
		if (arst_n) begin
			ev_took <= in_valid && in_ready;
			cfg_took <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				words_taken++;
				case (cfg_index)
				CFG_DELAY_FIRST, CFG_DELAY_SECOND, CFG_DELAY_THIRD, CFG_DELAY_FOURTH:
					dly_tbl[cfg_index[IDX_W-1:0]] = cfg_data;
				CFG_DELAYS_USED: begin
					// drop a zero entry count, keep the old one
					if (cfg_data[USED_W-1:0] != 0)
						entries_used = cfg_data[USED_W-1:0];
				end
				default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got_res = '{link_state_out, state_changed, open_request, close_request,
					report_message, next_delay_out, attempt_out, error_flag_out};
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result word %0d arrived with nothing outstanding", results_seen);
				end else begin
					want_res = results_due.pop_front();
					if (got_res !== want_res) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("result word %0d mismatch: expected link %0d chg %b open %b close %b msg %b delay %0d tries %0d err %b",
								results_seen, want_res.link, want_res.changed,
								want_res.open_req, want_res.close_req, want_res.report,
								want_res.delay, want_res.tries, want_res.err);
							$display("result word %0d mismatch: actual   link %0d chg %b open %b close %b msg %b delay %0d tries %0d err %b",
								results_seen, got_res.link, got_res.changed,
								got_res.open_req, got_res.close_req, got_res.report,
								got_res.delay, got_res.tries, got_res.err);
						end
					end
				end
				results_seen++;
			end
			if (in_valid && in_ready) begin
				words_taken++;
				results_due.push_back(next_link_result(action, want_value, reason_present));
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus: directed events first, then phases of register settings each
	// followed by random event traffic. Then drain and report.
	initial begin
		logic [DELAY_W-1:0] pd [DELAY_REGS];
		logic [DELAY_W-1:0] pu;
		int span;
		int quota;
		int r;

		// directed: corner events under reset delays (5/10/20/30, four in use)
		queue_event(ACT_TICK, 1'b0, 1'b0);         // idle timer, nothing happens
		queue_event(ACT_DISCONNECTED, 1'b1, 1'b0); // not wanted: off
		queue_event(ACT_FAILED, 1'b0, 1'b1);       // not wanted: ignored
		queue_event(ACT_UNAVAILABLE, 1'b0, 1'b1);  // not wanted: ignored
		queue_event(ACT_SPARE_LO, 1'b0, 1'b0);
		queue_event(ACT_SPARE_HI, 1'b1, 1'b1);
		queue_event(ACT_SET_WANTED, 1'b0, 1'b1);   // close
		queue_event(ACT_SET_WANTED, 1'b1, 1'b0);   // open, connecting
		queue_event(ACT_DISCONNECTED, 1'b0, 1'b1); // wanted but not up: no change
		queue_event(ACT_UNAVAILABLE, 1'b1, 1'b1);  // not up: no change
		queue_event(ACT_FAILED, 1'b0, 1'b1);       // first retry
		queue_event(ACT_FAILED, 1'b1, 1'b0);       // second retry
		queue_event(ACT_CONNECTED, 1'b0, 1'b0);    // recovered message
		queue_event(ACT_UNAVAILABLE, 1'b0, 1'b1);
		queue_event(ACT_CONNECTED, 1'b1, 1'b1);    // error recorded: message
		queue_event(ACT_DISCONNECTED, 1'b0, 1'b0); // loss of wanted link: retry
		repeat (5)
			queue_event(ACT_TICK, 1'b0, 1'b0);     // last one fires the open
		queue_event(ACT_TICK, 1'b1, 1'b1);         // timer stopped
		queue_event(ACT_CONNECTED, 1'b0, 1'b1);
		queue_event(ACT_SET_WANTED, 1'b0, 1'b0);
		queue_event(ACT_FAILED, 1'b1, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			span = 10;
			quota = events_planned + PHASE_WORDS;
			case (p)
			0: begin
				// zero and one delays, the widest delay, oversized entry count
				pd = '{16'd0, 16'd1, 16'hFFFF, 16'd2};
				pu = 16'd7;
			end
			1: begin
				for (int i = 0; i < DELAY_REGS; i++)
					pd[i] = DELAY_W'($urandom_range(0, 6));
				pu = 16'd1;
			end
			2: begin
				// long delays so a run of failures saturates the attempt count
				pd = '{16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF};
				pu = 16'hFFFC;
				span = 4;
				quota = events_planned + PHASE_WORDS + 80;
			end
			3: begin
				pd = '{RST_DELAY_FIRST, RST_DELAY_SECOND, RST_DELAY_THIRD, RST_DELAY_FOURTH};
				pu = DELAY_W'(RST_DELAYS_USED);
				span = 32;
			end
			default: begin
				for (int i = 0; i < DELAY_REGS; i++)
					pd[i] = ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom) :
						DELAY_W'($urandom_range(0, 8));
				pu = DELAY_W'($urandom_range(0, 7));
			end
			endcase
			queue_reg(CFG_DELAY_FIRST, pd[0]);
			queue_reg(CFG_DELAY_SECOND, pd[1]);
			queue_reg(CFG_DELAY_THIRD, pd[2]);
			queue_reg(CFG_DELAY_FOURTH, pd[3]);
			queue_reg(CFG_DELAYS_USED, pu);
			if (p == 1) begin
				queue_reg(CFG_DELAYS_USED, 16'd0); // dropped, one entry stays
				queue_reg(CFG_SPARE, 16'hA5A5);    // no register there
			end

			if (p == 0) begin
				queue_event(ACT_SET_WANTED, 1'b1, 1'b1);
				queue_event(ACT_FAILED, 1'b0, 1'b0); // zero delay
				queue_event(ACT_TICK, 1'b0, 1'b0);
				queue_event(ACT_FAILED, 1'b1, 1'b1); // one second delay
				queue_event(ACT_TICK, 1'b1, 1'b0);
				queue_event(ACT_FAILED, 1'b0, 1'b1); // widest delay
				queue_event(ACT_CONNECTED, 1'b0, 1'b0);
			end
			if (p == 2) begin
				queue_event(ACT_SET_WANTED, 1'b1, 1'b0);
				for (int i = 0; i < 262; i++) begin
					queue_event(ACT_FAILED, coin(), coin());
					if (i % 40 == 39)
						queue_event(ACT_TICK, 1'b0, 1'b0);
				end
			end

			while (events_planned < quota) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					// retry round: fail or lose the link, tick it out, reconnect
					if ($urandom_range(0, 9) < 3)
						queue_event(ACT_SET_WANTED, 1'b1, coin());
					if ($urandom_range(0, 1)) begin
						queue_event(ACT_CONNECTED, coin(), coin());
						queue_event(ACT_DISCONNECTED, coin(), coin());
					end else begin
						queue_event(ACT_FAILED, coin(), coin());
					end
					repeat ($urandom_range(0, span))
						queue_event(ACT_TICK, coin(), coin());
					if ($urandom_range(0, 9) < 6)
						queue_event(ACT_CONNECTED, coin(), coin());
				end else if (r < 70) begin
					// link goes unavailable while up
					queue_event(ACT_CONNECTED, coin(), coin());
					queue_event(ACT_UNAVAILABLE, coin(), coin());
					repeat ($urandom_range(0, 3))
						queue_event(ACT_TICK, coin(), coin());
					queue_event($urandom_range(0, 1) ? ACT_CONNECTED : ACT_FAILED,
						coin(), coin());
				end else if (r < 80) begin
					repeat ($urandom_range(2, 24))
						queue_event(ACT_FAILED, coin(), coin());
				end else begin
					queue_event(ACTION_W'($urandom_range(0, 7)), coin(), coin());
				end
			end
		end

		// drain: every word taken and every result back, then a short settle
		while (words_taken != words_planned || results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Hold reset, then release it on a falling edge
	initial begin
		arst_n = 1'b0;
		repeat (10)
			@(negedge clk);
		arst_n = 1'b1;
	end

endmodule
